### rtl/core/hrrn_dispatcher_assert.svh
// Assertion macros for the HRRN dispatcher.
// No dependencies; included by files that carry concurrent checks.
`ifndef HRRN_DISPATCHER_ASSERT_SVH
`define HRRN_DISPATCHER_ASSERT_SVH

`ifndef SYNTHESIS
`define HRRN_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("hrrn check failed");
`define HRRN_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("hrrn check failed");
`else
`define HRRN_ASSERT_SAME(label, clk, rstn, ante, cons)
`define HRRN_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

### rtl/core/hrrn_pkg.sv
// Shared constants and beat types for the HRRN dispatcher.
// No dependencies.
`default_nettype none

package hrrn_pkg;

    localparam int SLOT_COUNT = 16;
    localparam int TIME_BITS  = 16;
    localparam int BURST_BITS = 12;
    localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int NUM_W      = ((TIME_BITS > BURST_BITS) ? TIME_BITS : BURST_BITS) + 1;
    localparam int PROD_W     = NUM_W + BURST_BITS;
    localparam int ENTRY_W    = TIME_BITS + BURST_BITS;

    typedef struct packed {
        logic        arrival_valid;
        logic [3:0]  arrival_slot;
        logic [11:0] arrival_burst;
    } in_beat_t;

    typedef struct packed {
        logic        busy_res;
        logic [3:0]  running_slot;
        logic        arrival_rejected;
        logic        completed;
        logic [3:0]  completed_slot;
        logic [15:0] completion_time;
        logic [15:0] turnaround_cnt;
        logic [15:0] waiting_time;
    } out_beat_t;

endpackage

`default_nettype wire

### rtl/core/hrrn_dispatcher.sv
// HRRN dispatcher top level: slot table in RAM, serial ratio scan, run step.
// Depends on hrrn_pkg, hrrn_ram and hrrn_dispatcher_assert.svh.
//
//  channel | ports                      | payload     | one beat is
//  --------+----------------------------+-------------+--------------------------
//  input   | s_valid, s_ready, s_data   | in_beat_t   | one time tick (+arrival)
//  result  | m_valid, m_ready, m_data   | out_beat_t  | status of that tick
//
// A tick with a job already running goes through accept, then the run step.
// A tick with no job running adds the selection scan, which reads the
// SLOT_COUNT table entries one per cycle through the single RAM read port
// into one shared cross-multiply comparator, then drains the read and candidate registers.
// Reset is synchronous, active low; the table needs no clearing (valid bits).
// The run step waits while the output register holds an untaken beat.
`default_nettype none

`include "hrrn_dispatcher_assert.svh"

module hrrn_dispatcher
    import hrrn_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_beat_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_beat_t      m_data
);

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_RUN} state_t;

    state_t                  state_reg;
    logic [TIME_BITS-1:0]    time_reg;
    logic [SLOT_COUNT-1:0]   occ_reg;
    logic                    run_reg;
    logic [SLOT_W-1:0]       act_slot_reg;
    logic [BURST_BITS-1:0]   remain_reg;
    logic [TIME_BITS-1:0]    act_arr_reg;
    logic [BURST_BITS-1:0]   act_burst_reg;
    logic                    rej_reg;
    logic [SLOT_W:0]         scan_cnt_reg;
    logic                    rd_vld_reg;
    logic [SLOT_W-1:0]       rd_slot_reg;
    logic                    cand_vld_reg;
    logic [SLOT_W-1:0]       cand_slot_reg;
    logic [NUM_W-1:0]        cand_num_reg;
    logic [BURST_BITS-1:0]   cand_burst_reg;
    logic [TIME_BITS-1:0]    cand_arr_reg;
    logic                    best_vld_reg;
    logic [SLOT_W-1:0]       best_slot_reg;
    logic [NUM_W-1:0]        best_num_reg;
    logic [BURST_BITS-1:0]   best_burst_reg;
    logic [TIME_BITS-1:0]    best_arr_reg;
    logic                    m_valid_reg;
    out_beat_t               m_data_reg;

    logic                    acc;
    logic                    slot_ok;
    logic [SLOT_W-1:0]       arr_idx;
    logic [BURST_BITS-1:0]   arr_burst;
    logic                    arr_ok;
    logic                    ram_we;
    logic [ENTRY_W-1:0]      ram_wdata;
    logic                    scan_issue;
    logic                    ram_re;
    logic [SLOT_W-1:0]       ram_raddr;
    logic [ENTRY_W-1:0]      ram_rdata;
    logic [TIME_BITS-1:0]    rd_arr;
    logic [BURST_BITS-1:0]   rd_burst;
    logic [TIME_BITS-1:0]    rd_wait;
    logic [NUM_W-1:0]        rd_num;
    logic [PROD_W-1:0]       cand_prod;
    logic [PROD_W-1:0]       best_prod;
    logic                    cand_wins;
    logic                    scan_done;
    logic [TIME_BITS-1:0]    time_next;
    logic                    job_done;
    logic [TIME_BITS-1:0]    tat;
    logic [TIME_BITS-1:0]    wt;
    logic                    out_free;
    out_beat_t               out_next;

    assign acc       = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign slot_ok   = (int'(s_data.arrival_slot) < SLOT_COUNT);
    assign arr_idx   = SLOT_W'(s_data.arrival_slot);
    assign arr_burst = BURST_BITS'(s_data.arrival_burst);
    assign arr_ok    = slot_ok && (arr_burst != '0) && !occ_reg[arr_idx];
    assign ram_we    = acc && s_data.arrival_valid && arr_ok;
    assign ram_wdata = {time_reg, arr_burst};

    assign scan_issue = (scan_cnt_reg < (SLOT_W + 1)'(SLOT_COUNT));
    assign ram_re     = (state_reg == ST_SCAN) && scan_issue;
    assign ram_raddr  = scan_cnt_reg[SLOT_W-1:0];

    hrrn_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOT_COUNT)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (arr_idx),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ratio compare: (wc+bc)*bb > (wb+bb)*bc
    assign rd_arr    = ram_rdata[ENTRY_W-1:BURST_BITS];
    assign rd_burst  = ram_rdata[BURST_BITS-1:0];
    assign rd_wait   = time_reg - rd_arr;
    assign rd_num    = NUM_W'(rd_wait) + NUM_W'(rd_burst);
    assign cand_prod = cand_num_reg * best_burst_reg;
    assign best_prod = best_num_reg * cand_burst_reg;
    assign cand_wins = cand_vld_reg && (!best_vld_reg || (cand_prod > best_prod));
    assign scan_done = !scan_issue && !rd_vld_reg && !cand_vld_reg;

    assign time_next = time_reg + TIME_BITS'(1);
    assign job_done  = run_reg && (remain_reg <= BURST_BITS'(1));
    assign tat       = time_next - act_arr_reg;
    assign wt        = tat - TIME_BITS'(act_burst_reg);
    assign out_free  = !m_valid_reg || m_ready;

    always_comb begin
        out_next                  = '0;
        out_next.busy_res         = run_reg;
        out_next.running_slot     = run_reg ? 4'(act_slot_reg) : 4'd0;
        out_next.arrival_rejected = rej_reg;
        out_next.completed        = job_done;
        if (job_done) begin
            out_next.completed_slot  = 4'(act_slot_reg);
            out_next.completion_time = 16'(time_next);
            out_next.turnaround_cnt  = 16'(tat);
            out_next.waiting_time    = 16'(wt);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            time_reg     <= '0;
            occ_reg      <= '0;
            run_reg      <= 1'b0;
            act_slot_reg <= '0;
            remain_reg   <= '0;
            scan_cnt_reg <= '0;
            rd_vld_reg   <= 1'b0;
            cand_vld_reg <= 1'b0;
            best_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && (state_reg != ST_RUN)) begin
                m_valid_reg <= 1'b0;
            end

            rd_vld_reg     <= ram_re;
            rd_slot_reg    <= ram_raddr;
            cand_vld_reg   <= rd_vld_reg && occ_reg[rd_slot_reg];
            cand_slot_reg  <= rd_slot_reg;
            cand_num_reg   <= rd_num;
            cand_burst_reg <= rd_burst;
            cand_arr_reg   <= rd_arr;

            if (cand_wins) begin
                best_vld_reg   <= 1'b1;
                best_slot_reg  <= cand_slot_reg;
                best_num_reg   <= cand_num_reg;
                best_burst_reg <= cand_burst_reg;
                best_arr_reg   <= cand_arr_reg;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (acc) begin
                        rej_reg      <= s_data.arrival_valid && !arr_ok;
                        if (ram_we) begin
                            occ_reg[arr_idx] <= 1'b1;
                        end
                        scan_cnt_reg <= '0;
                        best_vld_reg <= 1'b0;
                        state_reg    <= run_reg ? ST_RUN : ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (scan_issue) begin
                        scan_cnt_reg <= scan_cnt_reg + (SLOT_W + 1)'(1);
                    end
                    if (scan_done) begin
                        if (best_vld_reg) begin
                            run_reg       <= 1'b1;
                            act_slot_reg  <= best_slot_reg;
                            remain_reg    <= best_burst_reg;
                            act_arr_reg   <= best_arr_reg;
                            act_burst_reg <= best_burst_reg;
                        end
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= out_next;
                        time_reg    <= time_next;
                        if (run_reg) begin
                            if (job_done) begin
                                occ_reg[act_slot_reg] <= 1'b0;
                                run_reg               <= 1'b0;
                                remain_reg            <= '0;
                            end else begin
                                remain_reg <= remain_reg - BURST_BITS'(1);
                            end
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `HRRN_ASSERT_SAME(a_run_slot_held, aclk, aresetn, run_reg, occ_reg[act_slot_reg])
    `HRRN_ASSERT_SAME(a_done_when_busy, aclk, aresetn, m_valid_reg && m_data_reg.completed, m_data_reg.busy_res)
    `HRRN_ASSERT_NEXT(a_running_skips_scan, aclk, aresetn, acc && run_reg, state_reg == ST_RUN)

endmodule

`default_nettype wire

### rtl/core/hrrn_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module hrrn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                    aclk,
    input  wire logic                                    we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic                                    re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire
